[design/ttl_pkg.sv]
package ttl_pkg;

    // Input transfer: one text byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } src_t;

    // Output transfer: one token
    typedef struct packed {
        logic [3:0]  tok_kind;
        logic [31:0] tok_start;
        logic [15:0] tok_length;
        logic        bool_value;
        logic [1:0]  error_kind;
        logic        run_last;
    } tok_t;

    // Lexer mode
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_STR,
        MODE_WORD,
        MODE_CMT,
        MODE_HALT
    } mode_t;

    // Token kinds
    localparam logic [3:0] KIND_NUM    = 4'd0;
    localparam logic [3:0] KIND_STR    = 4'd1;
    localparam logic [3:0] KIND_BOOL   = 4'd2;
    localparam logic [3:0] KIND_KEY    = 4'd3;
    localparam logic [3:0] KIND_LBRACE = 4'd4;
    localparam logic [3:0] KIND_RBRACE = 4'd5;
    localparam logic [3:0] KIND_LBRACK = 4'd6;
    localparam logic [3:0] KIND_RBRACK = 4'd7;
    localparam logic [3:0] KIND_EQUAL  = 4'd8;
    localparam logic [3:0] KIND_NL     = 4'd9;
    localparam logic [3:0] KIND_END    = 4'd10;
    localparam logic [3:0] KIND_ERR    = 4'd11;

    // Error kinds
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CHAR    = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;

    // Characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Progress of a letter run against "true" / "false"
    localparam logic [3:0] MATCH_NONE  = 4'd0;
    localparam logic [3:0] MATCH_T     = 4'd1;
    localparam logic [3:0] MATCH_TR    = 4'd2;
    localparam logic [3:0] MATCH_TRU   = 4'd3;
    localparam logic [3:0] MATCH_TRUE  = 4'd4;
    localparam logic [3:0] MATCH_F     = 4'd5;
    localparam logic [3:0] MATCH_FA    = 4'd6;
    localparam logic [3:0] MATCH_FAL   = 4'd7;
    localparam logic [3:0] MATCH_FALS  = 4'd8;
    localparam logic [3:0] MATCH_FALSE = 4'd9;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    localparam int MAX_RES    = 3;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // space, tab, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic [3:0] match_step(input logic [3:0] m, input logic [7:0] c);
        logic [3:0] r;
        r = MATCH_NONE;
        case (m)
            MATCH_T:    r = (c == "r") ? MATCH_TR    : MATCH_NONE;
            MATCH_TR:   r = (c == "u") ? MATCH_TRU   : MATCH_NONE;
            MATCH_TRU:  r = (c == "e") ? MATCH_TRUE  : MATCH_NONE;
            MATCH_F:    r = (c == "a") ? MATCH_FA    : MATCH_NONE;
            MATCH_FA:   r = (c == "l") ? MATCH_FAL   : MATCH_NONE;
            MATCH_FAL:  r = (c == "s") ? MATCH_FALS  : MATCH_NONE;
            MATCH_FALS: r = (c == "e") ? MATCH_FALSE : MATCH_NONE;
            default:    r = MATCH_NONE;
        endcase
        return r;
    endfunction

endpackage

[design/toml_token_lexer_unit.sv]
// Channel  | valid      | stall      | payload
// ---------+------------+------------+-------------------------------
// source   | src_valid  | src_stall  | src_data (ttl_pkg::src_t)
// tokens   | tok_valid  | tok_stall  | tok_data (ttl_pkg::tok_t)
//
// One byte is lexed per cycle: the byte, the mode and the run registers
// feed one pass of decode logic that writes up to three tokens into an
// eight-entry output queue. Tokens leave it one per unstalled cycle, so a
// byte that gives two or three tokens costs extra output cycles.
// src_stall rises while fewer than three queue slots are free.
// Reset (rst_n low) clears the mode, offsets and queue at once.
module toml_token_lexer_unit #(
    parameter int POS_BITS = 32,
    parameter int LEN_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_valid,
    output logic            src_stall,
    input  ttl_pkg::src_t   src_data,
    output logic            tok_valid,
    input  logic            tok_stall,
    output ttl_pkg::tok_t   tok_data
);

    localparam int PW = (POS_BITS > 32) ? POS_BITS : 32;
    localparam int LW = (LEN_BITS > 16) ? LEN_BITS : 16;

    // Lexer state
    ttl_pkg::mode_t          mode_reg, mode_next;
    logic [POS_BITS-1:0]     pos_reg, pos_next;
    logic [POS_BITS-1:0]     begin_reg, begin_next;
    logic [3:0]              match_reg, match_next;
    logic [LEN_BITS-1:0]     len_reg, len_next;

    // Output queue
    ttl_pkg::tok_t                 fifo_reg [ttl_pkg::FIFO_DEPTH];
    logic [ttl_pkg::PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ttl_pkg::CNT_W-1:0]     count_reg, count_next;

    ttl_pkg::tok_t  res [ttl_pkg::MAX_RES];
    logic [1:0]     n_res;
    logic           accept;
    logic           pop;
    logic           done;
    logic [7:0]     c;

    function automatic ttl_pkg::tok_t mk_tok(
        input logic [3:0]          kind,
        input logic [POS_BITS-1:0] start,
        input logic [LEN_BITS-1:0] len,
        input logic                bval,
        input logic [1:0]          ek
    );
        ttl_pkg::tok_t t;
        logic [PW-1:0] s;
        logic [LW-1:0] l;
        s            = PW'(start);
        l            = LW'(len);
        t.tok_kind   = kind;
        t.tok_start  = s[31:0];
        t.tok_length = l[15:0];
        t.bool_value = bval;
        t.error_kind = ek;
        t.run_last   = 1'b0;
        return t;
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
        return (v == '1) ? v : v + LEN_BITS'(1);
    endfunction

    function automatic ttl_pkg::tok_t word_tok(
        input logic [3:0]          m,
        input logic [POS_BITS-1:0] start,
        input logic [LEN_BITS-1:0] len
    );
        ttl_pkg::tok_t t;
        if (m == ttl_pkg::MATCH_TRUE)
        begin
            t = mk_tok(ttl_pkg::KIND_BOOL, start, len, 1'b1, ttl_pkg::ERR_NONE);
        end
        else if (m == ttl_pkg::MATCH_FALSE)
        begin
            t = mk_tok(ttl_pkg::KIND_BOOL, start, len, 1'b0, ttl_pkg::ERR_NONE);
        end
        else
        begin
            t = mk_tok(ttl_pkg::KIND_KEY, start, len, 1'b0, ttl_pkg::ERR_NONE);
        end
        return t;
    endfunction

    // Handshakes
    assign src_stall = (count_reg > ttl_pkg::CNT_W'(ttl_pkg::FIFO_DEPTH - ttl_pkg::MAX_RES));
    assign accept    = src_valid && !src_stall;
    assign tok_valid = (count_reg != '0);
    assign pop       = tok_valid && !tok_stall;
    assign tok_data  = fifo_reg[rd_ptr_reg];
    assign c         = src_data.in_byte;

    // Lex one byte: next state and up to three tokens
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        match_next = match_reg;
        len_next   = len_reg;
        done       = 1'b0;
        n_res      = 2'd0;
        for (int i = 0; i < ttl_pkg::MAX_RES; i++)
        begin
            res[i] = '0;
        end

        if (accept && (mode_reg != ttl_pkg::MODE_HALT))
        begin
            // continue a pending run
            case (mode_reg)
                ttl_pkg::MODE_NUM:
                begin
                    if (ttl_pkg::is_digit(c))
                    begin
                        len_next = sat_inc(len_reg);
                        done     = 1'b1;
                    end
                    else
                    begin
                        res[n_res] = mk_tok(ttl_pkg::KIND_NUM, begin_reg, len_reg, 1'b0,
                                            ttl_pkg::ERR_NONE);
                        n_res      = n_res + 2'd1;
                        mode_next  = ttl_pkg::MODE_IDLE;
                    end
                end
                ttl_pkg::MODE_WORD:
                begin
                    if (ttl_pkg::is_alpha(c))
                    begin
                        len_next   = sat_inc(len_reg);
                        match_next = ttl_pkg::match_step(match_reg, c);
                        done       = 1'b1;
                    end
                    else
                    begin
                        res[n_res] = word_tok(match_reg, begin_reg, len_reg);
                        n_res      = n_res + 2'd1;
                        mode_next  = ttl_pkg::MODE_IDLE;
                    end
                end
                ttl_pkg::MODE_STR:
                begin
                    done = 1'b1;
                    if (c == ttl_pkg::CH_QUOTE)
                    begin
                        res[n_res] = mk_tok(ttl_pkg::KIND_STR, begin_reg, len_reg, 1'b0,
                                            ttl_pkg::ERR_NONE);
                        n_res      = n_res + 2'd1;
                        mode_next  = ttl_pkg::MODE_IDLE;
                    end
                    else if (c == ttl_pkg::CH_NL)
                    begin
                        res[n_res] = mk_tok(ttl_pkg::KIND_ERR, begin_reg, len_reg, 1'b0,
                                            ttl_pkg::ERR_UNTERM);
                        n_res      = n_res + 2'd1;
                        mode_next  = ttl_pkg::MODE_HALT;
                    end
                    else
                    begin
                        len_next = sat_inc(len_reg);
                    end
                end
                ttl_pkg::MODE_CMT:
                begin
                    done = 1'b1;
                    if (c == ttl_pkg::CH_NL)
                    begin
                        mode_next = ttl_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // lex the byte from idle
            if (!done)
            begin
                if (ttl_pkg::is_blank(c))
                begin
                end
                else if (c == ttl_pkg::CH_HASH)
                begin
                    mode_next = ttl_pkg::MODE_CMT;
                end
                else if (ttl_pkg::is_digit(c))
                begin
                    mode_next  = ttl_pkg::MODE_NUM;
                    begin_next = pos_reg;
                    len_next   = LEN_BITS'(1);
                end
                else if (ttl_pkg::is_alpha(c))
                begin
                    mode_next  = ttl_pkg::MODE_WORD;
                    begin_next = pos_reg;
                    len_next   = LEN_BITS'(1);
                    match_next = (c == "t") ? ttl_pkg::MATCH_T :
                                 (c == "f") ? ttl_pkg::MATCH_F : ttl_pkg::MATCH_NONE;
                end
                else if (c == ttl_pkg::CH_QUOTE)
                begin
                    mode_next  = ttl_pkg::MODE_STR;
                    begin_next = pos_reg + POS_BITS'(1);
                    len_next   = '0;
                end
                else if (c == ttl_pkg::CH_LBRACE)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_LBRACE, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (c == ttl_pkg::CH_RBRACE)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_RBRACE, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (c == ttl_pkg::CH_LBRACK)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_LBRACK, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (c == ttl_pkg::CH_RBRACK)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_RBRACK, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (c == ttl_pkg::CH_EQUAL)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_EQUAL, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (c == ttl_pkg::CH_NL)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_NL, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_ERR, pos_reg, LEN_BITS'(1), 1'b0,
                                        ttl_pkg::ERR_CHAR);
                    n_res      = n_res + 2'd1;
                    mode_next  = ttl_pkg::MODE_HALT;
                end
            end

            pos_next = pos_reg + POS_BITS'(1);

            // end of text: flush, then END and a fresh start; an open string halts instead
            if (src_data.end_of_text && (mode_next != ttl_pkg::MODE_HALT))
            begin
                if (mode_next == ttl_pkg::MODE_NUM)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_NUM, begin_next, len_next, 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                end
                else if (mode_next == ttl_pkg::MODE_WORD)
                begin
                    res[n_res] = word_tok(match_next, begin_next, len_next);
                    n_res      = n_res + 2'd1;
                end
                else if (mode_next == ttl_pkg::MODE_STR)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_ERR, begin_next, len_next, 1'b0,
                                        ttl_pkg::ERR_UNTERM);
                    n_res      = n_res + 2'd1;
                    mode_next  = ttl_pkg::MODE_HALT;
                end

                if (mode_next != ttl_pkg::MODE_HALT)
                begin
                    res[n_res] = mk_tok(ttl_pkg::KIND_END, pos_next, '0, 1'b0,
                                        ttl_pkg::ERR_NONE);
                    n_res      = n_res + 2'd1;
                    mode_next  = ttl_pkg::MODE_IDLE;
                    pos_next   = '0;
                    begin_next = '0;
                    match_next = ttl_pkg::MATCH_NONE;
                    len_next   = '0;
                end
            end

            // mark the last token of this byte
            if (n_res != 2'd0)
            begin
                res[n_res - 2'd1].run_last = 1'b1;
            end
        end
    end

    // Queue occupancy
    always_comb
    begin
        count_next = count_reg + ttl_pkg::CNT_W'(n_res) - ttl_pkg::CNT_W'(pop);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ttl_pkg::MODE_IDLE;
            pos_reg    <= '0;
            begin_reg  <= '0;
            match_reg  <= ttl_pkg::MATCH_NONE;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            match_reg  <= match_next;
            len_reg    <= len_next;
            wr_ptr_reg <= wr_ptr_reg + ttl_pkg::PTR_W'(n_res);
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ttl_pkg::PTR_W'(1);
            end
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ttl_pkg::MAX_RES; i++)
        begin
            if (ttl_pkg::CNT_W'(i) < ttl_pkg::CNT_W'(n_res))
            begin
                fifo_reg[wr_ptr_reg + ttl_pkg::PTR_W'(i)] <= res[i];
            end
        end
    end

endmodule

[design/ttl_checker.sv]
module ttl_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    input  logic            tok_stall,
    input  ttl_pkg::tok_t   tok_data
);

    // A stalled token holds
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
        else $error("stalled token changed or dropped");

    // Error code only on error tokens, and an error closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_data.error_kind != ttl_pkg::ERR_NONE) |->
            (tok_data.tok_kind == ttl_pkg::KIND_ERR) && tok_data.run_last)
        else $error("error code on a non-error token");

    // END has no text and closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_data.tok_kind == ttl_pkg::KIND_END) |->
            (tok_data.tok_length == '0) && tok_data.run_last)
        else $error("malformed END token");

    // Bool value set only on bool tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.bool_value |-> (tok_data.tok_kind == ttl_pkg::KIND_BOOL))
        else $error("bool value on a non-bool token");

    // Punctuation and newline tokens are one byte long
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_data.tok_kind >= ttl_pkg::KIND_LBRACE) &&
            (tok_data.tok_kind <= ttl_pkg::KIND_NL) |-> (tok_data.tok_length == 16'd1))
        else $error("single-byte token with wrong length");

endmodule

bind toml_token_lexer_unit ttl_checker u_ttl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
);

[tb/toml_token_lexer_unit_tb.sv]
`timescale 1ns / 1ps

module toml_token_lexer_unit_tb;
    import ttl_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] TRUE_TXT  [0:3] = '{"t", "r", "u", "e"};
    localparam logic [7:0] FALSE_TXT [0:4] = '{"f", "a", "l", "s", "e"};

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  src_valid = 1'b0;
    logic  src_stall;
    src_t  src_data  = '0;
    logic  tok_valid;
    logic  tok_stall = 1'b0;
    tok_t  tok_data;

    // quiet stretches: neither side idles while set
    logic  no_idle     = 1'b0;
    int    errors      = 0;
    int    cycle_count = 0;

    // lexer state as predicted
    mode_t       lex_mode_q;
    logic [31:0] next_pos;
    logic [31:0] run_begin;
    logic [3:0]  word_prog;
    logic [15:0] run_len;
    tok_t        expected_tokens[$];

    toml_token_lexer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // character classes
    function automatic logic digit_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic space_char(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    // one-byte token kind, KIND_ERR when the byte is not one of them
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        case (c)
            CH_LBRACE: return KIND_LBRACE;
            CH_RBRACE: return KIND_RBRACE;
            CH_LBRACK: return KIND_LBRACK;
            CH_RBRACK: return KIND_RBRACK;
            CH_EQUAL:  return KIND_EQUAL;
            CH_NL:     return KIND_NL;
            default:   return KIND_ERR;
        endcase
    endfunction

    function automatic logic [3:0] word_after(input logic [3:0] m, input logic [7:0] c);
        logic [7:0] want;
        want = 8'h00;
        if (m >= MATCH_T && m <= MATCH_TRU)
            want = TRUE_TXT[m];
        else if (m >= MATCH_F && m <= MATCH_FALS)
            want = FALSE_TXT[m - 4];
        return (want != 8'h00 && c == want) ? m + 4'd1 : MATCH_NONE;
    endfunction

    function automatic logic [15:0] grow(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic [31:0] start,
                                    input logic [15:0] len, input logic bv,
                                    input logic [1:0] ek);
        tok_t t;
        t.tok_kind   = kind;
        t.tok_start  = start;
        t.tok_length = len;
        t.bool_value = bv;
        t.error_kind = ek;
        t.run_last   = 1'b0;
        return t;
    endfunction

    function automatic tok_t word_tok();
        if (word_prog == MATCH_TRUE)
            return mk_tok(KIND_BOOL, run_begin, run_len, 1'b1, ERR_NONE);
        if (word_prog == MATCH_FALSE)
            return mk_tok(KIND_BOOL, run_begin, run_len, 1'b0, ERR_NONE);
        return mk_tok(KIND_KEY, run_begin, run_len, 1'b0, ERR_NONE);
    endfunction

    task automatic clear_lexer();
        lex_mode_q = MODE_IDLE;
        next_pos   = '0;
        run_begin  = '0;
        word_prog  = MATCH_NONE;
        run_len    = '0;
    endtask

    // tokens caused by one accepted byte
    task automatic predict_tokens(input logic [7:0] c, input logic last);
        tok_t        found[$];
        logic        taken;
        logic [31:0] here;
        logic [3:0]  pk;
        here  = next_pos;
        taken = 1'b0;
        pk    = punct_kind(c);
        if (lex_mode_q == MODE_HALT)
            return;

        // continue or close the pending run
        case (lex_mode_q)
            MODE_NUM:
                if (digit_char(c))
                begin
                    run_len = grow(run_len);
                    taken   = 1'b1;
                end
                else
                begin
                    found.push_back(mk_tok(KIND_NUM, run_begin, run_len, 1'b0, ERR_NONE));
                    lex_mode_q = MODE_IDLE;
                end
            MODE_WORD:
                if (letter_char(c))
                begin
                    run_len   = grow(run_len);
                    word_prog = word_after(word_prog, c);
                    taken     = 1'b1;
                end
                else
                begin
                    found.push_back(word_tok());
                    lex_mode_q = MODE_IDLE;
                end
            MODE_STR:
            begin
                taken = 1'b1;
                if (c == CH_QUOTE)
                begin
                    found.push_back(mk_tok(KIND_STR, run_begin, run_len, 1'b0, ERR_NONE));
                    lex_mode_q = MODE_IDLE;
                end
                else if (c == CH_NL)
                begin
                    found.push_back(mk_tok(KIND_ERR, run_begin, run_len, 1'b0, ERR_UNTERM));
                    lex_mode_q = MODE_HALT;
                end
                else
                    run_len = grow(run_len);
            end
            MODE_CMT:
            begin
                taken = 1'b1;
                if (c == CH_NL)
                    lex_mode_q = MODE_IDLE;
            end
            default: ;
        endcase

        // byte lexed from idle
        if (!taken)
        begin
            if (c == CH_HASH)
                lex_mode_q = MODE_CMT;
            else if (digit_char(c))
            begin
                lex_mode_q = MODE_NUM;
                run_begin  = here;
                run_len    = 16'd1;
            end
            else if (letter_char(c))
            begin
                lex_mode_q = MODE_WORD;
                run_begin  = here;
                run_len    = 16'd1;
                word_prog  = (c == "t") ? MATCH_T : (c == "f") ? MATCH_F : MATCH_NONE;
            end
            else if (c == CH_QUOTE)
            begin
                lex_mode_q = MODE_STR;
                run_begin  = here + 32'd1;
                run_len    = '0;
            end
            else if (pk != KIND_ERR)
                found.push_back(mk_tok(pk, here, 16'd1, 1'b0, ERR_NONE));
            else if (!space_char(c))
            begin
                found.push_back(mk_tok(KIND_ERR, here, 16'd1, 1'b0, ERR_CHAR));
                lex_mode_q = MODE_HALT;
            end
        end

        next_pos = here + 32'd1;

        // end of text: flush, then END and a fresh start; an open string halts instead
        if (last && lex_mode_q != MODE_HALT)
        begin
            if (lex_mode_q == MODE_NUM)
                found.push_back(mk_tok(KIND_NUM, run_begin, run_len, 1'b0, ERR_NONE));
            else if (lex_mode_q == MODE_WORD)
                found.push_back(word_tok());
            else if (lex_mode_q == MODE_STR)
            begin
                found.push_back(mk_tok(KIND_ERR, run_begin, run_len, 1'b0, ERR_UNTERM));
                lex_mode_q = MODE_HALT;
            end
            if (lex_mode_q != MODE_HALT)
            begin
                found.push_back(mk_tok(KIND_END, next_pos, 16'd0, 1'b0, ERR_NONE));
                clear_lexer();
            end
        end

        if (found.size() > 0)
            found[found.size() - 1].run_last = 1'b1;
        foreach (found[i])
            expected_tokens.push_back(found[i]);
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random byte allowed inside a string or a comment
    function automatic logic [7:0] text_byte(input logic in_string);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_NL || (in_string && b == CH_QUOTE));
        return b;
    endfunction

    // one source transfer; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_data  <= '{in_byte: b, end_of_text: last};
        src_valid <= 1'b1;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        predict_tokens(b, last);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // token checker: outputs taken at the rising edge, compared just after
    always
    begin : token_check
        tok_t seen;
        tok_t want;
        @(posedge clk);
        if (tok_valid === 1'b1 && tok_stall === 1'b0)
        begin
            seen = tok_data;
            #1;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: no token expected, got kind %0d start %0h len %0h",
                         $time, seen.tok_kind, seen.tok_start, seen.tok_length);
            end
            else
            begin
                want = expected_tokens.pop_front();
                cmp_field("tok_kind",   32'(want.tok_kind),   32'(seen.tok_kind));
                cmp_field("tok_start",  want.tok_start,       seen.tok_start);
                cmp_field("tok_length", 32'(want.tok_length), 32'(seen.tok_length));
                cmp_field("bool_value", 32'(want.bool_value), 32'(seen.bool_value));
                cmp_field("error_kind", 32'(want.error_kind), 32'(seen.error_kind));
                cmp_field("run_last",   32'(want.run_last),   32'(seen.run_last));
            end
        end
    end

    // token sink stalls
    always
    begin : sink_stall
        int n;
        @(negedge clk);
        if (no_idle || $urandom_range(0, 3) != 0)
            tok_stall <= 1'b0;
        else
        begin
            tok_stall <= 1'b1;
            n = idle_len();
            repeat (n) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("toml_token_lexer_unit_tb NOT OK");
            $finish;
        end
    end

    // punctuation, bool flushed by '}', comment swallowing its newline, END
    task automatic test_punct_comment();
        send_text("{true}[=\n#\377\n", 1'b1);
    endtask

    // number flushed by letter, false flushed by '=', key then ']' then END
    task automatic test_runs();
        send_text("9false=Ab]", 1'b1);
    endtask

    // strings with odd content, empty string, comment dropped at end of text
    task automatic test_strings();
        send_text("\"a#\200\"\"\"#", 1'b1);
    endtask

    // long string sent back to back
    task automatic test_long_string();
        no_idle = 1'b1;
        send_byte(CH_QUOTE, 1'b0);
        repeat (24) send_byte(text_byte(1'b1), 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        no_idle = 1'b0;
    endtask

    // well-formed texts built from random segments
    task automatic test_random_text(input int target);
        logic [7:0] seg[$];
        int         sent;
        int         n;
        logic       fin;
        string      w;
        sent = 0;
        while (sent < target)
        begin
            if (sent % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            seg.delete();
            fin = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0, 8:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) seg.push_back(8'h30 + 8'($urandom_range(0, 9)));
                end
                1, 9:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        n = $urandom_range(1, 6);
                        repeat (n)
                            seg.push_back(($urandom_range(0, 1) ? 8'h61 : 8'h41)
                                          + 8'($urandom_range(0, 25)));
                    end
                    else
                    begin
                        w = $urandom_range(0, 1) ? "true" : "false";
                        n = $urandom_range(1, w.len());
                        for (int i = 0; i < n; i++)
                            seg.push_back(w[i]);
                        if ($urandom_range(0, 3) == 0)
                            seg.push_back(8'h61 + 8'($urandom_range(0, 25)));
                    end
                end
                2:
                begin
                    seg.push_back(CH_QUOTE);
                    n = $urandom_range(0, 8);
                    repeat (n) seg.push_back(text_byte(1'b1));
                    seg.push_back(CH_QUOTE);
                end
                3, 4:
                begin
                    case ($urandom_range(0, 4))
                        0: seg.push_back(CH_LBRACE);
                        1: seg.push_back(CH_RBRACE);
                        2: seg.push_back(CH_LBRACK);
                        3: seg.push_back(CH_RBRACK);
                        default: seg.push_back(CH_EQUAL);
                    endcase
                end
                5: seg.push_back(CH_NL);
                6:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        case ($urandom_range(0, 4))
                            0: seg.push_back(8'h20);
                            1: seg.push_back(8'h09);
                            2: seg.push_back(8'h0B);
                            3: seg.push_back(8'h0C);
                            default: seg.push_back(8'h0D);
                        endcase
                end
                default:
                begin
                    seg.push_back(CH_HASH);
                    n = $urandom_range(0, 6);
                    repeat (n) seg.push_back(text_byte(1'b0));
                    if (!(fin && $urandom_range(0, 1)))
                        seg.push_back(CH_NL);
                end
            endcase
            foreach (seg[i])
                send_byte(seg[i], fin && (i == seg.size() - 1));
            sent += seg.size();
        end
        no_idle = 1'b0;
    endtask

    // one error of a random kind, then the halted block must stay silent
    task automatic test_error_halt();
        logic [7:0] b;
        int         n;
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte("7", 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (digit_char(b) || letter_char(b) || space_char(b) || b == CH_HASH ||
                       b == CH_QUOTE || punct_kind(b) != KIND_ERR);
                send_byte(b, 1'($urandom_range(0, 1)));
            end
            1:
            begin
                send_byte(CH_QUOTE, 1'b0);
                n = $urandom_range(0, 3);
                repeat (n) send_byte(text_byte(1'b1), 1'b0);
                send_byte(CH_NL, 1'($urandom_range(0, 1)));
            end
            default:
            begin
                n = $urandom_range(0, 3);
                send_byte(CH_QUOTE, n == 0);
                for (int i = 0; i < n; i++)
                    send_byte(text_byte(1'b1), i == n - 1);
            end
        endcase
        repeat (16) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        clear_lexer();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_punct_comment();
        test_runs();
        test_strings();
        test_long_string();
        test_random_text(180);
        test_error_halt();

        src_valid <= 1'b0;
        wait (expected_tokens.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("toml_token_lexer_unit_tb OK");
        else
            $display("toml_token_lexer_unit_tb NOT OK");
        $finish;
    end

endmodule
